FILE: src/mssel_pkg.sv
// ----------------------------------------------------------------------------
// mssel_pkg: shared definitions for the masked subset select engine
// Command codes, register indexes, fixed field widths and the pipeline
// control bundle passed between the top level and its controller.
// ----------------------------------------------------------------------------
package mssel_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned FIELD_W    = 64;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;

  // Default number of mask bits in use.
  localparam int unsigned DEF_MASK_BITS = 64;

  // Bits per group of the two-level prefix count.
  localparam int unsigned GRP_BITS = 8;

  // Register stages between the input and the output port.
  localparam int unsigned NUM_STAGES = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST    = 3'd0,
    CMD_NEXT     = 3'd1,
    CMD_SELECT   = 3'd2,
    CMD_RANK     = 3'd3,
    CMD_POPCOUNT = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPERSET = 1'b0,
    CFG_SIZE     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctrl_t;

endpackage

FILE: src/mssel_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// mssel_pipe_ctrl: valid tracking and stage enables
// Keeps one valid bit per register stage and works out which stages may
// load this cycle, so that bubbles close up and a stalled output holds.
// ----------------------------------------------------------------------------
module mssel_pipe_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_stall_i,
  output mssel_pkg::pipe_ctrl_t ctrl_o
);
  import mssel_pkg::*;

  localparam int unsigned LAST = NUM_STAGES - 1;

  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] en;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[LAST] = !vld_q[LAST] || !out_stall_i;
    for (int i = int'(LAST) - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_comb begin
    vld_d    = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int i = 1; i < int'(NUM_STAGES); i++) begin
      if (en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl_o.en  = en;
  assign ctrl_o.vld = vld_q;

  // Input backpressure only appears when every stage is full and the output is stalled.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en[0] |-> ((&vld_q) && out_stall_i))
    else $error("input stalled while the pipeline has a bubble");

  // A stage is only held while it carries a transaction.
  a_hold_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((~en & ~vld_q) == '0))
    else $error("empty stage held");

  // Transactions in flight change only by acceptance and delivery.
  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(vld_q) == $past($countones(vld_q))
      + $past(int'(in_valid_i && en[0])) - $past(int'(vld_q[LAST] && !out_stall_i))))
    else $error("transaction lost or duplicated in the pipeline");

endmodule

FILE: src/masked_subset_select_engine_unit.sv
// ----------------------------------------------------------------------------
// masked_subset_select_engine_unit: k-subset stepping and bit select/rank
// Steps through k-subsets of a superset mask in colex order and answers
// select, rank and popcount queries on a subset mask.
// ----------------------------------------------------------------------------
// Every transaction passes through seven register stages, and a new
// transaction can be accepted in every cycle; the input stalls only when
// all seven stages are full and the output is stalled. The depth is set by
// the next-subset path: a two-level prefix bit count (two stages), trimming
// the subset to its k highest bits, two lowest-set-bit isolations, the
// lookup of the counts below the pivot bit and the final low fill. The
// configuration port is always ready; registers must only be written while
// no transaction is in flight. No clearing pass is needed after reset.
module masked_subset_select_engine_unit #(
  parameter int unsigned MASK_BITS = mssel_pkg::DEF_MASK_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration writes.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mssel_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mssel_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Command input.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [mssel_pkg::CMD_W-1:0]          cmd_i,
  input  logic [mssel_pkg::FIELD_W-1:0]        subset_mask_i,
  input  logic [mssel_pkg::POS_W-1:0]          position_i,
  // Result output.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mssel_pkg::FIELD_W-1:0]        result_mask_o,
  output logic signed [mssel_pkg::IDX_W-1:0]   result_index_o,
  output logic                                 found_o
);
  import mssel_pkg::*;

  localparam int unsigned MB   = MASK_BITS;
  localparam int unsigned GRP  = GRP_BITS;
  localparam int unsigned NG   = (MB + GRP - 1) / GRP;
  localparam int unsigned PW   = NG * GRP;
  localparam int unsigned LW   = $clog2(GRP + 1);
  localparam int unsigned CW   = $clog2(MB + 1);
  localparam int unsigned IW   = $clog2(MB);
  localparam int unsigned LAST = NUM_STAGES - 1;

  typedef struct packed {
    cmd_e                         cmd;
    logic [POS_W-1:0]             pos;
    logic [CNT_W-1:0]             k;
    logic [MB-1:0]                t;
    logic [MB-1:0]                s;
    logic [NG-1:0][LW-1:0]        grp_t;
    logic [NG-1:0][LW-1:0]        grp_s;
    logic [MB-1:0][CW-1:0]        pinc_t;
    logic [MB-1:0][CW-1:0]        pinc_s;
    logic [CW-1:0]                pop_t;
    logic [CW-1:0]                pop_s;
    logic [MB-1:0]                tk;
    logic [MB-1:0]                cand;
    logic [MB-1:0]                piv;
    logic [MB-1:0]                sel_hot;
    logic [CNT_W-1:0]             need;
    logic                         ok;
    logic [MB-1:0]                res_mask;
    logic signed [IDX_W-1:0]      res_idx;
    logic                         found;
  } stage_t;

  logic [MB-1:0]    superset_q;
  logic [CNT_W-1:0] size_q;

  pipe_ctrl_t ctrl;
  stage_t     st_q [NUM_STAGES];
  stage_t     st_d [NUM_STAGES];

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      superset_q <= '0;
      size_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SUPERSET: superset_q <= cfg_data_i[MB-1:0];
        CFG_SIZE:     size_q     <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  mssel_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  assign in_stall_o = !ctrl.en[0];

  // --------------------------------------------------------------------------
  // Stage 1: capture and count bits within each group.
  // --------------------------------------------------------------------------
  always_comb begin : p_stage1
    logic [PW-1:0]          tp;
    logic [PW-1:0]          sp;
    logic [LW-1:0]          acc_t;
    logic [LW-1:0]          acc_s;
    logic [PW-1:0][LW-1:0]  loc_t;
    logic [PW-1:0][LW-1:0]  loc_s;
    st_d[0]     = '0;
    st_d[0].cmd = cmd_e'(cmd_i);
    st_d[0].pos = position_i;
    st_d[0].k   = size_q;
    st_d[0].t   = subset_mask_i[MB-1:0];
    st_d[0].s   = superset_q;
    tp = PW'(subset_mask_i[MB-1:0]);
    sp = PW'(superset_q);
    for (int g = 0; g < int'(NG); g++) begin
      acc_t = '0;
      acc_s = '0;
      for (int j = 0; j < int'(GRP); j++) begin
        acc_t = acc_t + LW'(tp[g*GRP+j]);
        acc_s = acc_s + LW'(sp[g*GRP+j]);
        loc_t[g*GRP+j] = acc_t;
        loc_s[g*GRP+j] = acc_s;
      end
      st_d[0].grp_t[g] = acc_t;
      st_d[0].grp_s[g] = acc_s;
    end
    for (int b = 0; b < int'(MB); b++) begin
      st_d[0].pinc_t[b] = CW'(loc_t[b]);
      st_d[0].pinc_s[b] = CW'(loc_s[b]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: group offsets give the inclusive prefix count at every bit.
  // --------------------------------------------------------------------------
  always_comb begin : p_stage2
    logic [NG-1:0][CW-1:0] off_t;
    logic [NG-1:0][CW-1:0] off_s;
    st_d[1]  = st_q[0];
    off_t[0] = '0;
    off_s[0] = '0;
    for (int g = 1; g < int'(NG); g++) begin
      off_t[g] = off_t[g-1] + CW'(st_q[0].grp_t[g-1]);
      off_s[g] = off_s[g-1] + CW'(st_q[0].grp_s[g-1]);
    end
    for (int b = 0; b < int'(MB); b++) begin
      st_d[1].pinc_t[b] = st_q[0].pinc_t[b] + off_t[b/GRP];
      st_d[1].pinc_s[b] = st_q[0].pinc_s[b] + off_s[b/GRP];
    end
    st_d[1].pop_t = off_t[NG-1] + CW'(st_q[0].grp_t[NG-1]);
    st_d[1].pop_s = off_s[NG-1] + CW'(st_q[0].grp_s[NG-1]);
  end

  // --------------------------------------------------------------------------
  // Stage 3: first, rank and popcount finish; select finds its bit and next
  // trims the subset to its k highest bits.
  // --------------------------------------------------------------------------
  always_comb begin : p_stage3
    logic [CNT_W-1:0] pop_t7;
    logic [CNT_W-1:0] pop_s7;
    logic [CNT_W-1:0] ord;
    logic [CW-1:0]    drop;
    logic [CW-1:0]    rank_cnt;
    logic [MB-1:0]    first_mask;
    st_d[2]  = st_q[1];
    pop_t7   = CNT_W'(st_q[1].pop_t);
    pop_s7   = CNT_W'(st_q[1].pop_s);
    ord      = CNT_W'(st_q[1].pos) + CNT_W'(1);
    // Number of low bits of T that fall outside its k highest bits.
    drop     = st_q[1].pop_t - st_q[1].k[CW-1:0];
    rank_cnt = '0;
    for (int b = 0; b < int'(MB); b++) begin
      first_mask[b]      = st_q[1].s[b] && (CNT_W'(st_q[1].pinc_s[b]) <= st_q[1].k);
      st_d[2].tk[b]      = st_q[1].t[b] && (st_q[1].pinc_t[b] > drop);
      st_d[2].sel_hot[b] = st_q[1].t[b] && (CNT_W'(st_q[1].pinc_t[b]) == ord);
      if (st_q[1].pos == POS_W'(b)) begin
        rank_cnt = rank_cnt | st_q[1].pinc_t[b];
      end
    end
    st_d[2].ok       = (st_q[1].k != '0) && (pop_t7 >= st_q[1].k);
    st_d[2].res_mask = '0;
    st_d[2].res_idx  = '0;
    st_d[2].found    = 1'b0;
    case (st_q[1].cmd)
      CMD_FIRST: begin
        st_d[2].found    = (pop_s7 >= st_q[1].k);
        st_d[2].res_mask = st_d[2].found ? first_mask : '0;
      end
      CMD_NEXT: begin
      end
      CMD_SELECT: begin
        st_d[2].found = (pop_t7 > CNT_W'(st_q[1].pos));
      end
      CMD_RANK: begin
        if (CNT_W'(st_q[1].pos) < CNT_W'(MB)) begin
          st_d[2].found   = 1'b1;
          st_d[2].res_idx = IDX_W'(rank_cnt) - IDX_W'(1);
        end else begin
          st_d[2].res_idx = '1;
        end
      end
      CMD_POPCOUNT: begin
        st_d[2].found   = 1'b1;
        st_d[2].res_idx = IDX_W'(st_q[1].pop_t);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 4: select encodes its index; next forms the pivot candidates.
  // --------------------------------------------------------------------------
  always_comb begin : p_stage4
    logic [IW-1:0] enc;
    logic [MB-1:0] above;
    st_d[3] = st_q[2];
    enc     = '0;
    for (int b = 0; b < int'(MB); b++) begin
      if (st_q[2].sel_hot[b]) begin
        enc = enc | IW'(b);
      end
    end
    if (st_q[2].cmd == CMD_SELECT) begin
      st_d[3].res_idx = st_q[2].found ? IDX_W'(enc) : '1;
    end
    // Bits strictly above the lowest bit of the trimmed subset.
    above        = ~(st_q[2].tk ^ (st_q[2].tk - MB'(1)));
    st_d[3].cand = st_q[2].s & ~st_q[2].tk & above;
  end

  // --------------------------------------------------------------------------
  // Stage 5: the pivot is the lowest candidate.
  // --------------------------------------------------------------------------
  always_comb begin : p_stage5
    st_d[4]     = st_q[3];
    st_d[4].piv = st_q[3].cand & (~st_q[3].cand + MB'(1));
    st_d[4].ok  = st_q[3].ok && (st_q[3].cand != '0);
  end

  // --------------------------------------------------------------------------
  // Stage 6: keep the subset bits above the pivot and work out how many low
  // superset bits must be filled in below it.
  // --------------------------------------------------------------------------
  always_comb begin : p_stage6
    logic [CW-1:0] cnt_t;
    logic [CW-1:0] cnt_s;
    logic [MB-1:0] high;
    st_d[5] = st_q[4];
    cnt_t   = '0;
    cnt_s   = '0;
    for (int b = 0; b < int'(MB); b++) begin
      if (st_q[4].piv[b]) begin
        cnt_t = cnt_t | st_q[4].pinc_t[b];
        cnt_s = cnt_s | st_q[4].pinc_s[b];
      end
    end
    // The pivot is never in T, so every T bit above it is kept.
    high         = st_q[4].t & ~(st_q[4].piv | (st_q[4].piv - MB'(1)));
    st_d[5].need = st_q[4].k - CNT_W'(1) - CNT_W'(st_q[4].pop_t) + CNT_W'(cnt_t);
    // The pivot is a superset bit, so cnt_s - 1 superset bits lie below it.
    st_d[5].ok   = st_q[4].ok && (st_d[5].need < CNT_W'(cnt_s));
    if (st_q[4].cmd == CMD_NEXT) begin
      st_d[5].res_mask = high | st_q[4].piv;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: fill with the lowest superset bits and finish next.
  // --------------------------------------------------------------------------
  always_comb begin : p_stage7
    logic [MB-1:0] fill;
    st_d[6] = st_q[5];
    for (int b = 0; b < int'(MB); b++) begin
      fill[b] = st_q[5].s[b] && (CNT_W'(st_q[5].pinc_s[b]) <= st_q[5].need);
    end
    if (st_q[5].cmd == CMD_NEXT) begin
      st_d[6].res_mask = st_q[5].ok ? (st_q[5].res_mask | fill) : '0;
      st_d[6].res_idx  = '0;
      st_d[6].found    = st_q[5].ok;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(NUM_STAGES); i++) begin
      if (ctrl.en[i]) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign out_valid_o    = ctrl.vld[LAST];
  assign result_mask_o  = FIELD_W'(st_q[LAST].res_mask);
  assign result_index_o = st_q[LAST].res_idx;
  assign found_o        = st_q[LAST].found;

  // An accepted transaction always occupies the first stage next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ctrl.vld[0])
    else $error("accepted transaction missing from the first stage");

  // A failed search never carries a mask.
  a_fail_no_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (result_mask_o == '0))
    else $error("mask reported with found low");

  // Mask results come only from subset commands, which report index zero.
  a_mask_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_mask_o != '0)) |-> (result_index_o == '0))
    else $error("mask result with a nonzero index");

endmodule

FILE: tb/tb_masked_subset_select_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_masked_subset_select_engine_unit: self-checking bench for the subset engine
// Drives first/next/select/rank/popcount commands under several superset and
// size settings, predicts every result in-line and compares it field by field
// with what comes out, while both handshake sides idle at random in most rounds.
// ----------------------------------------------------------------------------
module tb_masked_subset_select_engine_unit;
  import mssel_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] mask;
    logic [IDX_W-1:0]   index;
    logic               found;
  } subset_result_t;

  class subset_result_tracker;
    logic [FIELD_W-1:0] superset;
    logic [CNT_W-1:0]   size;
    subset_result_t     pending[$];
    int unsigned        errors;

    function new();
      superset = '0;
      size     = '0;
      errors   = 0;
    endfunction

    static function int ones(logic [FIELD_W-1:0] m);
      int n;
      n = 0;
      for (int b = 0; b < FIELD_W; b++) n += m[b];
      return n;
    endfunction

    // The n lowest set bits of m, or all of m if it has fewer.
    static function logic [FIELD_W-1:0] lowest_bits(logic [FIELD_W-1:0] m, int n);
      logic [FIELD_W-1:0] r;
      logic [FIELD_W-1:0] b;
      r = '0;
      while (m != '0 && n > 0) begin
        b = m & (~m + 64'd1);
        r |= b;
        m &= ~b;
        n--;
      end
      return r;
    endfunction

    function subset_result_t predict(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] t,
                                     logic [POS_W-1:0] pos);
      subset_result_t     r;
      int                 k;
      int                 need;
      int                 seen;
      logic [FIELD_W-1:0] tk, lo, above, cand, c, high, below, window;
      r = '0;
      k = int'(size);
      case (cmd)
        CMD_FIRST: begin
          if (ones(superset) >= k) begin
            r.mask  = lowest_bits(superset, k);
            r.found = 1'b1;
          end
        end
        CMD_NEXT: begin
          if (k != 0 && ones(t) >= k) begin
            // Only the k highest bits of the operand take part.
            tk = t;
            while (ones(tk) > k) tk = tk & (tk - 64'd1);
            lo    = tk & (~tk + 64'd1);
            above = ~((lo << 1) - 64'd1);
            cand  = superset & ~tk & above;
            if (cand != '0) begin
              c     = cand & (~cand + 64'd1);
              high  = tk & ~((c << 1) - 64'd1);
              need  = k - 1 - ones(high);
              below = superset & (c - 64'd1);
              if (ones(below) >= need) begin
                r.mask  = high | c | lowest_bits(below, need);
                r.found = 1'b1;
              end
            end
          end
        end
        CMD_SELECT: begin
          r.index = '1;
          seen    = 0;
          for (int b = 0; b < FIELD_W; b++) begin
            if (t[b]) begin
              if (seen == int'(pos) && !r.found) begin
                r.index = IDX_W'(b);
                r.found = 1'b1;
              end
              seen++;
            end
          end
        end
        CMD_RANK: begin
          window  = (pos == '1) ? '1 : ((64'd1 << (pos + 1)) - 64'd1);
          r.index = IDX_W'(ones(t & window) - 1);
          r.found = 1'b1;
        end
        CMD_POPCOUNT: begin
          r.index = IDX_W'(ones(t));
          r.found = 1'b1;
        end
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] t,
                               logic [POS_W-1:0] pos);
      pending.push_back(predict(cmd, t, pos));
    endfunction

    function void check_result(logic [FIELD_W-1:0] mask, logic [IDX_W-1:0] index,
                               logic found);
      subset_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, mask %h index %0d found %b",
                 $time, mask, $signed(index), found);
        errors++;
      end else begin
        exp = pending.pop_front();
        if (mask !== exp.mask) begin
          $display("%0t: result_mask mismatch, expected %h, got %h", $time, exp.mask, mask);
          errors++;
        end
        if (index !== exp.index) begin
          $display("%0t: result_index mismatch, expected %0d, got %0d",
                   $time, $signed(exp.index), $signed(index));
          errors++;
        end
        if (found !== exp.found) begin
          $display("%0t: found mismatch, expected %b, got %b", $time, exp.found, found);
          errors++;
        end
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;
  localparam int ROUNDS = 9;
  localparam int ROUND_ITEMS = 100;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_W'(CMD_POPCOUNT + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [CMD_W-1:0]          cmd_i;
  logic [FIELD_W-1:0]        subset_mask_i;
  logic [POS_W-1:0]          position_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [FIELD_W-1:0]        result_mask_o;
  logic signed [IDX_W-1:0]   result_index_o;
  logic                      found_o;

  subset_result_tracker board = new();
  int send_idle_pct = 22;
  int recv_idle_pct = 68;

  masked_subset_select_engine_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .subset_mask_i  (subset_mask_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_mask_o  (result_mask_o),
    .result_index_o (result_index_o),
    .found_o        (found_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [FIELD_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [FIELD_W-1:0] sparse_word();
    return random_word() & random_word() & random_word();
  endfunction

  function automatic logic [FIELD_W-1:0] random_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(FIELD_W - 1);
      3, 4: return sparse_word();
      5, 6: return random_word() | random_word() | random_word();
      default: return random_word();
    endcase
  endfunction

  // Leaves valid high after acceptance so the next transaction can follow
  // back to back without a second assignment in the same step.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] t,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    subset_mask_i <= t;
    position_i    <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_command(cmd, t, pos);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(input logic [FIELD_W-1:0] superset, input logic [CNT_W-1:0] size);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SUPERSET;
    cfg_data_i  <= superset;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.superset = superset;
    cfg_index_i <= CFG_SIZE;
    cfg_data_i  <= CFG_DATA_W'(size);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.size = size;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : result_monitor
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        board.check_result(result_mask_o, result_index_o, found_o);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [FIELD_W-1:0] superset;
    logic [CNT_W-1:0]   size;
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] t;
    logic [POS_W-1:0]   pos;
    logic [FIELD_W-1:0] chain_mask;
    logic               chain_live;
    subset_result_t     step;
    int                 roll;

    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_SUPERSET;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    cmd_i         <= CMD_FIRST;
    subset_mask_i <= '0;
    position_i    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers still at their reset values: empty superset, size zero.
    send_item(CMD_FIRST, '0, '0);
    send_item(CMD_NEXT, '1, '0);
    send_item(CMD_SELECT, '0, '0);
    send_item(CMD_SELECT, '1, '1);
    send_item(CMD_SELECT, 64'hA5, 6'd3);
    send_item(CMD_RANK, '0, '0);
    send_item(CMD_RANK, '1, '1);
    send_item(CMD_RANK, 64'h8000_0000_0000_0000, 6'd62);
    send_item(CMD_POPCOUNT, '1, '0);
    send_item(CMD_POPCOUNT, '0, '1);
    send_item(CMD_UNUSED_LO, '1, '1);
    send_item(CMD_UNUSED_HI, 64'h5555_AAAA_5555_AAAA, 6'd21);

    // Full superset and full size: the only subset is everything.
    configure('1, 7'd64);
    send_item(CMD_FIRST, '0, '0);
    send_item(CMD_NEXT, '1, '0);

    configure(64'h8000_0000_0000_00F3, 7'd3);
    send_item(CMD_FIRST, '0, '0);
    send_item(CMD_NEXT, 64'h13, '0);
    send_item(CMD_NEXT, 64'hFFFF, '0);
    send_item(CMD_NEXT, 64'h3, '0);
    send_item(CMD_NEXT, 64'h8000_0000_0000_00C0, '0);

    // Superset too small for the size, and too few bits below the pivot.
    configure(64'h8000_0000_0000_0001, 7'd3);
    send_item(CMD_FIRST, '0, '0);
    send_item(CMD_NEXT, 64'hE, '0);

    for (int round = 0; round < ROUNDS; round++) begin
      case (round)
        0: begin superset = sparse_word();  size = CNT_W'($urandom_range(1, 4)); end
        1: begin superset = '1;             size = 7'd64; end
        2: begin superset = random_word() | random_word();
                 size = CNT_W'($urandom_range(64)); end
        3: begin superset = '0;             size = '0; end
        4: begin superset = sparse_word();  size = CNT_W'($urandom_range(2, 6)); end
        5: begin superset = '1;             size = 7'd1; end
        6: begin superset = random_word();
                 size = CNT_W'(board.ones(superset)); end
        7: begin superset = sparse_word();  size = CNT_W'($urandom_range(1, 3)); end
        default: begin superset = random_word(); size = CNT_W'($urandom_range(64)); end
      endcase
      configure(superset, size);
      send_idle_pct = (round < 3) ? 22 : (round < 6) ? 68 : 0;
      recv_idle_pct = (round < 3) ? 68 : (round < 6) ? 22 : 0;
      chain_live = 1'b0;
      chain_mask = '0;

      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if (n == ROUND_ITEMS / 2 && round % 3 == 1)
          wait_drained();
        roll = $urandom_range(99);
        pos  = POS_W'($urandom_range(63));
        if (roll < 50) begin
          // Walk the colex sequence, feeding each result back as the operand.
          if (!chain_live || $urandom_range(19) == 0) begin
            if ($urandom_range(3) == 0) begin
              cmd = CMD_NEXT;
              t   = board.superset & random_operand();
            end else begin
              cmd = CMD_FIRST;
              t   = random_operand();
            end
          end else begin
            cmd = CMD_NEXT;
            t   = chain_mask;
          end
          step       = board.predict(cmd, t, pos);
          chain_mask = step.mask;
          chain_live = step.found;
        end else if (roll < 80) begin
          case ($urandom_range(2))
            0: cmd = CMD_SELECT;
            1: cmd = CMD_RANK;
            default: cmd = CMD_POPCOUNT;
          endcase
          t = random_operand();
          if ($urandom_range(1) == 0)
            pos = POS_W'($urandom_range(board.ones(t)));
        end else if (roll < 92) begin
          cmd = CMD_NEXT;
          t   = ($urandom_range(1) == 0) ? board.superset & random_operand()
                                         : random_operand();
        end else if (roll < 97) begin
          cmd = CMD_FIRST;
          t   = random_operand();
        end else begin
          cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
          t   = random_operand();
        end
        send_item(cmd, t, pos);
      end
    end

    wait_drained();
    repeat (NUM_STAGES + 4) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
